@@ sv/swaa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swaa_pkg
// Shared types and constants for the sensor window average alarm.
// ----------------------------------------------------------------------------
package swaa_pkg;

   localparam int MaxSensors = 32;
   localparam int WindowLen  = 5;
   localparam int EntryBits  = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
   localparam int SlotBits   = (WindowLen > 1) ? $clog2(WindowLen) : 1;
   localparam int RingDepth  = MaxSensors * WindowLen;
   localparam int RingBits   = (RingDepth > 1) ? $clog2(RingDepth) : 1;
   localparam int CntBits    = $clog2(WindowLen + 1);
   localparam int SumBits    = 16 + CntBits + 1;
   localparam int DivSteps   = SumBits;
   localparam int StepBits   = $clog2(DivSteps + 1);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HOT     = 3'd1;
   localparam logic [2:0] ST_COLD    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_MAPPED  = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;

   localparam logic CMD_MAP    = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic REG_MAX_TEMP = 1'b0;
   localparam logic REG_MIN_TEMP = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_WAIT,
      S_DECIDE,
      S_CLEAR,
      S_SUM_RD,
      S_SUM_ACC,
      S_DIV,
      S_RESULT,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

@@ sv/sensor_window_average_alarm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_window_average_alarm
// Per-sensor moving average with a high and low alarm.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tdata: command, node_id, room_id, reading
// rsp      out        tdata: status, average, valid_count, sensor_room
// csr      in         index 0 max_temp, index 1 min_temp
//
// A transaction searches every entry of the entry RAM, one entry at a time.
// A sample then writes its reading, reads the ring one reading at a time and
// runs a 20-step restoring divider before rsp_tvalid rises; a map item clears
// the ring before it answers, and an unknown sensor or a full table answers
// once the search is done. req_tready is high only when idle, so a stalled
// response holds off req and the next sample waits for it. Reset clears the table.
// ----------------------------------------------------------------------------
module sensor_window_average_alarm (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[0], node_id[16:1], room_id[32:17], reading[48:33], zeros
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0], average[18:3], valid_count[21:19], sensor_room[37:22], zeros
   output logic      [39:0] rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int EB = swaa_pkg::EntryBits;
   localparam int SB = swaa_pkg::SlotBits;
   localparam int RB = swaa_pkg::RingBits;
   localparam int CB = swaa_pkg::CntBits;
   localparam int UB = swaa_pkg::SumBits;
   localparam int MaxS = swaa_pkg::MaxSensors;

   swaa_pkg::state_type state_ff, state_in;

   logic signed [15:0] max_ff, min_ff;
   logic        cmd_ff, cmd_in;
   logic [15:0] id_ff, id_in, room_ff, room_in;
   logic signed [15:0] rdg_ff, rdg_in;
   logic [MaxS-1:0] valid_ff, valid_in;
   logic [EB-1:0] idx_ff, idx_in;
   logic        found_ff, found_in, free_ff, free_in;
   logic [EB-1:0] hit_ff, hit_in, freei_ff, freei_in, ent_ff, ent_in;
   logic [SB-1:0] slot_ff, slot_in, pos_ff, pos_in;
   logic signed [UB-1:0] sum_ff, sum_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [UB-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [swaa_pkg::StepBits-1:0] step_ff, step_in;
   logic [39:0] out_ff, out_in;
   logic [15:0] eroom_ff, eroom_in;

   logic          e_we;
   logic [EB-1:0] e_addr;
   logic [34+SB:0] e_wd, e_rd;
   logic          r_we;
   logic [RB-1:0] r_addr;
   logic [15:0]   r_wd, r_rd;

   swaa_ram #(.Width(35 + SB), .Depth(MaxS)) u_entry (
      .clock(clock), .wr_en(e_we), .addr(e_addr), .wr_data(e_wd), .rd_data(e_rd)
   );
   swaa_ram #(.Width(16), .Depth(swaa_pkg::RingDepth)) u_ring (
      .clock(clock), .wr_en(r_we), .addr(r_addr), .wr_data(r_wd), .rd_data(r_rd)
   );

   logic [RB-1:0] base;
   logic [UB-1:0] abs_sum, trial;
   logic signed [UB-1:0] avg;
   logic [2:0] st;
   logic [swaa_pkg::StepBits-1:0] bitpos;

   assign base = RB'(ent_ff * swaa_pkg::WindowLen);
   assign abs_sum = sum_ff[UB-1] ? UB'(-sum_ff) : UB'(sum_ff);
   assign bitpos = swaa_pkg::StepBits'(UB - 1) - step_ff;
   assign csr_ready = !reset;
   assign req_tready = (state_ff == swaa_pkg::S_IDLE) && !reset;
   assign rsp_tvalid = (state_ff == swaa_pkg::S_OUT);
   assign rsp_tdata = out_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; id_in = id_ff; room_in = room_ff;
      rdg_in = rdg_ff; valid_in = valid_ff; idx_in = idx_ff; found_in = found_ff;
      free_in = free_ff; hit_in = hit_ff; freei_in = freei_ff; ent_in = ent_ff;
      slot_in = slot_ff; pos_in = pos_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      quo_in = quo_ff; rem_in = rem_ff; step_in = step_ff; out_in = out_ff;
      eroom_in = eroom_ff;
      e_we = 1'b0; e_addr = idx_ff; e_wd = '0;
      r_we = 1'b0; r_addr = RB'(base + RB'(pos_ff)); r_wd = '0;
      trial = '0; avg = '0; st = swaa_pkg::ST_OK;
      case (state_ff)
         swaa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[0]; id_in = req_tdata[16:1];
               room_in = req_tdata[32:17]; rdg_in = req_tdata[48:33];
               idx_in = '0; found_in = 1'b0; free_in = 1'b0;
               state_in = swaa_pkg::S_SEARCH;
            end
         end
         swaa_pkg::S_SEARCH: begin
            state_in = swaa_pkg::S_SEARCH_WAIT;
         end
         swaa_pkg::S_SEARCH_WAIT: begin
            if (valid_ff[idx_ff]) begin
               if (!found_ff && e_rd[15:0] == id_ff) begin
                  found_in = 1'b1; hit_in = idx_ff;
                  slot_in = e_rd[34+SB:35]; eroom_in = e_rd[31:16];
               end
            end else if (!free_ff) begin
               free_in = 1'b1; freei_in = idx_ff;
            end
            if (idx_ff == EB'(MaxS - 1)) begin
               state_in = swaa_pkg::S_DECIDE;
            end else begin
               idx_in = idx_ff + EB'(1);
               state_in = swaa_pkg::S_SEARCH;
            end
         end
         swaa_pkg::S_DECIDE: begin
            out_in = '0; pos_in = '0; sum_in = '0; cnt_in = '0;
            if (cmd_ff == swaa_pkg::CMD_MAP) begin
               if (!found_ff && !free_ff) begin
                  out_in[2:0] = swaa_pkg::ST_FULL;
                  state_in = swaa_pkg::S_OUT;
               end else begin
                  ent_in = found_ff ? hit_ff : freei_ff;
                  e_we = 1'b1; e_addr = found_ff ? hit_ff : freei_ff;
                  e_wd = {SB'(0), 3'b0, room_ff, id_ff};
                  valid_in[found_ff ? hit_ff : freei_ff] = 1'b1;
                  out_in[2:0] = swaa_pkg::ST_MAPPED;
                  out_in[37:22] = room_ff;
                  state_in = swaa_pkg::S_CLEAR;
               end
            end else if (!found_ff) begin
               out_in[2:0] = swaa_pkg::ST_UNKNOWN;
               state_in = swaa_pkg::S_OUT;
            end else begin
               ent_in = hit_ff;
               e_we = 1'b1; e_addr = hit_ff;
               e_wd = {(slot_ff == SB'(swaa_pkg::WindowLen - 1)) ? SB'(0) : slot_ff + SB'(1),
                       3'b0, eroom_ff, id_ff};
               pos_in = slot_ff;
               state_in = swaa_pkg::S_CLEAR;
            end
         end
         swaa_pkg::S_CLEAR: begin
            r_we = 1'b1;
            if (cmd_ff == swaa_pkg::CMD_MAP) begin
               if (pos_ff == SB'(swaa_pkg::WindowLen - 1)) begin
                  state_in = swaa_pkg::S_OUT;
               end else begin
                  pos_in = pos_ff + SB'(1);
               end
            end else begin
               r_wd = rdg_ff; pos_in = '0;
               state_in = swaa_pkg::S_SUM_RD;
            end
         end
         swaa_pkg::S_SUM_RD: begin
            state_in = swaa_pkg::S_SUM_ACC;
         end
         swaa_pkg::S_SUM_ACC: begin
            if (r_rd != 16'd0) begin
               sum_in = sum_ff + UB'(signed'(r_rd));
               cnt_in = cnt_ff + CB'(1);
            end
            if (pos_ff == SB'(swaa_pkg::WindowLen - 1)) begin
               quo_in = '0; rem_in = '0; step_in = '0;
               state_in = swaa_pkg::S_DIV;
            end else begin
               pos_in = pos_ff + SB'(1);
               state_in = swaa_pkg::S_SUM_RD;
            end
         end
         swaa_pkg::S_DIV: begin
            trial = {rem_ff[UB-2:0], abs_sum[bitpos]};
            if (cnt_ff != '0 && trial >= UB'(cnt_ff)) begin
               rem_in = trial - UB'(cnt_ff);
               quo_in = {quo_ff[UB-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[UB-2:0], 1'b0};
            end
            step_in = step_ff + swaa_pkg::StepBits'(1);
            if (step_ff == swaa_pkg::StepBits'(swaa_pkg::DivSteps - 1)) begin
               state_in = swaa_pkg::S_RESULT;
            end
         end
         swaa_pkg::S_RESULT: begin
            avg = sum_ff[UB-1] ? -signed'(quo_ff) : signed'(quo_ff);
            if (cnt_ff != '0) begin
               if (avg > UB'(max_ff)) begin
                  st = swaa_pkg::ST_HOT;
               end else if (avg < signed'(UB'(min_ff))) begin
                  st = swaa_pkg::ST_COLD;
               end
            end
            out_in = '0;
            out_in[2:0] = st;
            out_in[18:3] = avg[15:0];
            out_in[21:19] = (cnt_ff > CB'(7)) ? 3'd7 : 3'(cnt_ff);
            out_in[37:22] = eroom_ff;
            state_in = swaa_pkg::S_OUT;
         end
         swaa_pkg::S_OUT: begin
            if (rsp_tready) begin
               state_in = swaa_pkg::S_IDLE;
            end
         end
         default: state_in = swaa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swaa_pkg::S_IDLE;
         valid_ff <= '0;
         max_ff   <= 16'sd5120;
         min_ff   <= 16'sd2560;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_valid && csr_index == swaa_pkg::REG_MAX_TEMP) max_ff <= csr_data;
         if (csr_valid && csr_index == swaa_pkg::REG_MIN_TEMP) min_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; id_ff <= id_in; room_ff <= room_in; rdg_ff <= rdg_in;
      idx_ff <= idx_in; found_ff <= found_in; free_ff <= free_in; hit_ff <= hit_in;
      freei_ff <= freei_in; ent_ff <= ent_in; slot_ff <= slot_in; pos_ff <= pos_in;
      sum_ff <= sum_in; cnt_ff <= cnt_in; quo_ff <= quo_in; rem_ff <= rem_in;
      step_ff <= step_in; out_ff <= out_in; eroom_ff <= eroom_in;
   end

endmodule
`default_nettype wire

@@ sv/swaa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swaa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module swaa_ram #(
   parameter int Width = 16,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

@@ sv/swaa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swaa_checker
// Port-level checks for the sensor window average alarm.
// ----------------------------------------------------------------------------
module swaa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");

   a_req_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid && !req_tready)
      else $error("response or ready right after a request transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd5)
      else $error("bad status code");

endmodule

bind sensor_window_average_alarm swaa_checker u_swaa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

@@ tb/sv/sensor_window_average_alarm_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_window_average_alarm_test
// Drives map and sample transactions with random gaps and output stalls,
// predicts each result from a private copy of the sensor table and the
// limits, and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module sensor_window_average_alarm_test;
   import swaa_pkg::*;

   localparam int LimitCycles = 1500000;

   typedef struct {
      logic        cmd;
      logic [15:0] sensor;
      logic [15:0] room;
      logic [15:0] reading;
   } req_item_type;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] average;
      logic [2:0]  count;
      logic [15:0] room;
   } rsp_item_type;

   typedef struct {
      req_item_type req;
      logic         known;
      rsp_item_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = REG_MAX_TEMP;
   logic [15:0] csr_data = '0;

   sensor_window_average_alarm dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   logic signed [15:0] hot_limit, cold_limit;
   logic               tab_valid [MaxSensors];
   logic [15:0]        tab_sensor [MaxSensors];
   logic [15:0]        tab_room [MaxSensors];
   int                 tab_slot [MaxSensors];
   logic signed [15:0] tab_ring [MaxSensors][WindowLen];

   rsp_item_type expected_rsps [$];
   int  errors = 0;
   int  n_rsp = 0, n_hot = 0, n_cold = 0, n_full = 0, n_unknown = 0;
   int  cycle = 0;
   logic long_stall = 1'b0;

   function automatic int find_sensor(logic [15:0] id);
      for (int i = 0; i < MaxSensors; i++)
         if (tab_valid[i] && tab_sensor[i] == id) return i;
      return -1;
   endfunction

   function automatic rsp_item_type predict_alarm(req_item_type r);
      rsp_item_type o;
      int e;
      longint sum, avg;
      int cnt;
      o = '{ST_OK, 16'd0, 3'd0, 16'd0};
      e = find_sensor(r.sensor);
      if (r.cmd == CMD_MAP) begin
         if (e < 0)
            for (int i = 0; i < MaxSensors; i++)
               if (!tab_valid[i]) begin
                  e = i;
                  break;
               end
         if (e < 0) begin
            o.status = ST_FULL;
            return o;
         end
         tab_valid[e] = 1'b1;
         tab_sensor[e] = r.sensor;
         tab_room[e] = r.room;
         tab_slot[e] = 0;
         for (int k = 0; k < WindowLen; k++) tab_ring[e][k] = '0;
         o.status = ST_MAPPED;
         o.room = r.room;
         return o;
      end
      if (e < 0) begin
         o.status = ST_UNKNOWN;
         return o;
      end
      tab_ring[e][tab_slot[e]] = r.reading;
      tab_slot[e] = (tab_slot[e] + 1) % WindowLen;
      sum = 0;
      cnt = 0;
      for (int k = 0; k < WindowLen; k++)
         if (tab_ring[e][k] != 0) begin
            sum += tab_ring[e][k];
            cnt++;
         end
      avg = 0;
      if (cnt != 0) begin
         avg = sum / cnt;
         if (avg > hot_limit) o.status = ST_HOT;
         else if (avg < cold_limit) o.status = ST_COLD;
      end
      o.average = avg[15:0];
      o.count = (cnt > 7) ? 3'd7 : cnt[2:0];
      o.room = tab_room[e];
      return o;
   endfunction

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LimitCycles) begin
         $display("sensor_window_average_alarm_test: done, errors");
         $finish;
      end
   end

   // Receiver: stall pattern plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (long_stall) rsp_tready <= 1'b0;
      else if (cycle % 64 < 20) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[2:0], rsp_tdata[18:3], rsp_tdata[21:19], rsp_tdata[37:22]};
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            $error("result transaction with none expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, got.status);
               errors++;
            end
            if (got.average !== want.average) begin
               $error("average: expected %h, actual %h", want.average, got.average);
               errors++;
            end
            if (got.count !== want.count) begin
               $error("valid_count: expected %0d, actual %0d", want.count, got.count);
               errors++;
            end
            if (got.room !== want.room) begin
               $error("sensor_room: expected %h, actual %h", want.room, got.room);
               errors++;
            end
            case (want.status)
               ST_HOT: n_hot++;
               ST_COLD: n_cold++;
               ST_FULL: n_full++;
               ST_UNKNOWN: n_unknown++;
               default: ;
            endcase
         end
      end
   end

   // The request stays offered after its transaction; idle_gap, when it draws a gap, and drain drop it.
   task automatic send_item(req_item_type r, logic known, rsp_item_type k);
      rsp_item_type p;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, r.reading, r.room, r.sensor, r.cmd};
      do @(posedge clock); while (!req_tready);
      p = predict_alarm(r);
      expected_rsps.push_back(known ? k : p);
   endtask

   task automatic idle_gap();
      int gap;
      if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 150);
      else gap = 0;
      if (gap > 0) req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_limit(logic idx, logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MAX_TEMP) hot_limit = v;
      else cold_limit = v;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_reading();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h7fff;
         2: return 16'h8000;
         3: return 16'($urandom_range(1024, 8192));
         default: return 16'($urandom());
      endcase
   endfunction

   dir_row_type dir_rows [$];
   logic [15:0] id_pool [$];

   initial begin
      req_item_type r;
      rsp_item_type none;
      int n;
      none = '{ST_OK, 16'd0, 3'd0, 16'd0};
      hot_limit = 16'sd5120;
      cold_limit = 16'sd2560;
      for (int i = 0; i < MaxSensors; i++) tab_valid[i] = 1'b0;

      dir_rows = '{
         '{'{CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0100}, 1'b1, '{ST_UNKNOWN, 0, 0, 0}},
         '{'{CMD_MAP, 16'hffff, 16'hffff, 16'h0000}, 1'b1, '{ST_MAPPED, 0, 0, 16'hffff}},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h0000}, 1'b1, '{ST_OK, 0, 0, 16'hffff}},
         '{'{CMD_SAMPLE, 16'hffff, 16'h1234, 16'h7fff}, 1'b1,
           '{ST_HOT, 16'h7fff, 1, 16'hffff}},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h8000}, 1'b0, none},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h1400}, 1'b0, none},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h0a00}, 1'b0, none},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'hffff}, 1'b0, none},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h0001}, 1'b0, none},
         '{'{CMD_MAP, 16'hffff, 16'h0042, 16'h5555}, 1'b1, '{ST_MAPPED, 0, 0, 16'h0042}},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h1400}, 1'b1,
           '{ST_OK, 16'h1400, 1, 16'h0042}},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h0a00}, 1'b1,
           '{ST_OK, 16'h0f00, 2, 16'h0042}},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h0000}, 1'b0, none},
         '{'{CMD_SAMPLE, 16'hffff, 16'h0000, 16'h0100}, 1'b0, none},
         '{'{CMD_MAP, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{ST_MAPPED, 0, 0, 0}},
         '{'{CMD_SAMPLE, 16'h0000, 16'h0000, 16'hfd00}, 1'b1,
           '{ST_COLD, 16'hfd00, 1, 0}},
         '{'{CMD_SAMPLE, 16'h0000, 16'h0000, 16'hfffd}, 1'b0, none}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
      // Fill the table to hit the full case, then sample an id never mapped.
      for (int i = 0; i < MaxSensors; i++) begin
         r = '{CMD_MAP, 16'h1000 + i[15:0], i[15:0], 16'h0};
         send_item(r, 1'b0, none);
      end
      r = '{CMD_MAP, 16'h2000, 16'h0777, 16'h0};
      send_item(r, 1'b1, '{ST_FULL, 0, 0, 0});
      r = '{CMD_SAMPLE, 16'h2000, 16'h0, 16'h0100};
      send_item(r, 1'b1, '{ST_UNKNOWN, 0, 0, 0});
      drain();

      // Mapped ids let samples average and maps overwrite; a few others stay unknown.
      id_pool.delete();
      for (int i = 0; i < MaxSensors; i++)
         if (tab_valid[i]) id_pool.push_back(tab_sensor[i]);
      for (int i = 0; i < 8; i++) id_pool.push_back(16'($urandom()));

      // Random phases with different limit settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_limit(REG_MAX_TEMP, 16'h7fff); write_limit(REG_MIN_TEMP, 16'h8000); end
            1: begin write_limit(REG_MAX_TEMP, 16'h8000); write_limit(REG_MIN_TEMP, 16'h7fff); end
            2: begin write_limit(REG_MAX_TEMP, 16'h1400); write_limit(REG_MIN_TEMP, 16'h0a00); end
            default: begin
               write_limit(REG_MAX_TEMP, 16'($urandom_range(2048, 8192)));
               write_limit(REG_MIN_TEMP, 16'($urandom_range(0, 4096)));
            end
         endcase
         if (phase == 3) begin
            fork
               begin
                  long_stall <= 1'b1;
                  repeat (3000) @(posedge clock);
                  long_stall <= 1'b0;
               end
            join_none
         end
         n = 0;
         while (n < 270) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               r.sensor = id_pool[$urandom_range(0, id_pool.size() - 1)];
               if ($urandom_range(0, 9) == 0) r.sensor = 16'($urandom());
               r.cmd = ($urandom_range(0, 6) == 0) ? CMD_MAP : CMD_SAMPLE;
               r.room = 16'($urandom());
               r.reading = rand_reading();
               send_item(r, 1'b0, none);
               n++;
            end
            idle_gap();
         end
         drain();
      end

      $display("covered %0d transactions: %0d hot, %0d cold, %0d table full, %0d unknown",
               n_rsp, n_hot, n_cold, n_full, n_unknown);
      $display("limits at both extremes, a long response hold-off and random request gaps");
      if (errors == 0)
         $display("sensor_window_average_alarm_test: done, clean");
      else
         $display("sensor_window_average_alarm_test: done, errors");
      $finish;
   end

   always @(posedge clock)
      if (!reset && expected_rsps.size() == 0 && cycle % 100000 == 0 && cycle > 0)
         $display("cycle %0d: %0d results, %0d hot, %0d cold, %0d full, %0d unknown",
                  cycle, n_rsp, n_hot, n_cold, n_full, n_unknown);

endmodule

@@ files.f @@
sv/swaa_pkg.sv
sv/swaa_ram.sv
sv/sensor_window_average_alarm.sv
sv/swaa_checker.sv
tb/sv/sensor_window_average_alarm_test.sv
